FILE: sv/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg - stepper homing positioner definitions
// Shared widths, reset values, register map and sequencer phase codes.
// ----------------------------------------------------------------------------
package shp_pkg;

  // microsteps per 100 um of travel
  localparam int unsigned MICROSTEPS = 16;

  // field widths
  localparam int unsigned TARGET_UM_W = 16;
  localparam int unsigned CNT_W       = 14;
  localparam int unsigned RATE_W      = 8;
  localparam int unsigned EXTRA_W     = 8;

  // saturation limit of the step counters
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // stream payload widths
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 16;

  // configuration port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned REG_IDX_W  = 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_HOME_EXTRA_STEPS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HOME_RAMP_RATE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIELD_RAMP_RATE  = 2'd2;

  // register reset values
  localparam logic [EXTRA_W-1:0] HOME_EXTRA_STEPS_RST = 8'd10;
  localparam logic [RATE_W-1:0]  HOME_RAMP_RATE_RST   = 8'd100;
  localparam logic [RATE_W-1:0]  FIELD_RAMP_RATE_RST  = 8'd50;

  // target after reset: 100 um
  localparam logic [CNT_W-1:0] TARGET_STEPS_RST = CNT_W'(MICROSTEPS);

  // input item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // sequencer phases
  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LATCH_HOME = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SEEK_OPTO  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_EXTRA      = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LATCH_FLD  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_LEAVE_OPTO = 3'd5;
  localparam logic [PHASE_W-1:0] PH_TRAVEL     = 3'd6;

  // micrometre to step conversion: (um * MICROSTEPS) / 100 by reciprocal
  localparam int unsigned PROD_W  = TARGET_UM_W + $clog2(MICROSTEPS + 1);
  localparam int unsigned RECIP_SH = PROD_W + 7;
  localparam logic [63:0] RECIP_64 = ((64'd1 << RECIP_SH) + 64'd99) / 64'd100;
  localparam int unsigned RECIP_W = PROD_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_64[RECIP_W-1:0];
  localparam int unsigned QUOT_W = PROD_W + RECIP_W - RECIP_SH;

endpackage

FILE: sv/stepper_homing_positioner_top.sv
// ----------------------------------------------------------------------------
// stepper_homing_positioner_top - homing then positioning step sequencer
// Start transactions load a target; tick transactions walk the homing and
// positioning phases and return the driver controls for that tick.
// ----------------------------------------------------------------------------
// each input transaction's result is registered into the output register when it is accepted
// throughput: one transaction per cycle while the output side does not stall, set by the single state update path
// a result that waits in the output register still lets a new input in the
// cycle the output side takes it
// reset: asynchronous, active low; clears the sequencer state and output valid,
// registers return to their default values
module stepper_homing_positioner_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: [15:0] target_um, [16] opto_engaged, [17] driver_latched, [23:18] zero
  input  logic [shp_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // tuser: [0] kind
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: [0] accepted, [1] step_level, [2] driver_enable, [3] direction,
  // [4] speed_reload, [12:5] rate_req, [13] busy_res, [14] done_res,
  // [15] pos_valid
  output logic [shp_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [shp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [shp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [shp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import shp_pkg::*;

  // configuration registers
  logic [EXTRA_W-1:0] home_extra_steps_q;
  logic [RATE_W-1:0]  home_ramp_rate_q;
  logic [RATE_W-1:0]  field_ramp_rate_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  // sequencer state
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [CNT_W-1:0]   step_count_q, step_count_d;
  logic               step_phase_q, step_phase_d;
  logic [CNT_W-1:0]   target_steps_q, target_steps_d;
  logic               active_q, active_d;
  logic               valid_flag_q, valid_flag_d;
  logic               move_dir_q, move_dir_d;
  logic               pin_level_q, pin_level_d;

  // output register
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;

  // input fields
  logic                   in_kind;
  logic [TARGET_UM_W-1:0] in_target_um;
  logic                   in_opto;
  logic                   in_latched;
  logic                   in_fire;

  // conversion datapath
  logic [PROD_W-1:0]         um_scaled;
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic [QUOT_W-1:0]         steps_raw;
  logic [CNT_W-1:0]          steps_sat;

  // per-item flags
  logic accepted, reload, done, stepping;

  assign in_kind      = s_axis_tuser;
  assign in_target_um = s_axis_tdata[TARGET_UM_W-1:0];
  assign in_opto      = s_axis_tdata[TARGET_UM_W];
  assign in_latched   = s_axis_tdata[TARGET_UM_W+1];

  // handshake: take a new item whenever the output slot is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // apb decode
  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_IDX_W+1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_HOME_EXTRA_STEPS: prdata = APB_DATA_W'(home_extra_steps_q);
      REG_HOME_RAMP_RATE:   prdata = APB_DATA_W'(home_ramp_rate_q);
      REG_FIELD_RAMP_RATE:  prdata = APB_DATA_W'(field_ramp_rate_q);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_extra_steps_q <= HOME_EXTRA_STEPS_RST;
      home_ramp_rate_q   <= HOME_RAMP_RATE_RST;
      field_ramp_rate_q  <= FIELD_RAMP_RATE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HOME_EXTRA_STEPS: home_extra_steps_q <= pwdata[EXTRA_W-1:0];
        REG_HOME_RAMP_RATE:   home_ramp_rate_q   <= pwdata[RATE_W-1:0];
        REG_FIELD_RAMP_RATE:  field_ramp_rate_q  <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // target in steps: um * MICROSTEPS / 100, exact through the reciprocal
  assign um_scaled  = PROD_W'(in_target_um) * PROD_W'(MICROSTEPS);
  assign recip_prod = (PROD_W+RECIP_W)'(um_scaled) * (PROD_W+RECIP_W)'(RECIP);
  assign steps_raw  = recip_prod[PROD_W+RECIP_W-1:RECIP_SH];
  assign steps_sat  = (steps_raw > QUOT_W'(CNT_MAX)) ? CNT_MAX : steps_raw[CNT_W-1:0];

  // sequencer next state
  always_comb begin
    phase_d        = phase_q;
    step_count_d   = step_count_q;
    step_phase_d   = step_phase_q;
    target_steps_d = target_steps_q;
    active_d       = active_q;
    valid_flag_d   = valid_flag_q;
    move_dir_d     = move_dir_q;
    pin_level_d    = pin_level_q;
    accepted       = 1'b0;
    reload         = 1'b0;
    done           = 1'b0;
    stepping       = 1'b0;

    if (in_kind == KIND_START) begin
      // start is ignored while a command runs
      if (!active_q) begin
        accepted       = 1'b1;
        active_d       = 1'b1;
        phase_d        = PH_IDLE;
        target_steps_d = steps_sat;
      end
    end else if (active_q) begin
      unique case (phase_q)
        PH_LATCH_HOME: begin
          if (in_latched) phase_d = PH_SEEK_OPTO;
        end
        PH_SEEK_OPTO: begin
          if (step_count_q != CNT_MAX) step_count_d = step_count_q + 1'b1;
          if (in_opto) begin
            step_count_d = '0;
            phase_d      = PH_EXTRA;
          end else begin
            stepping = 1'b1;
          end
        end
        PH_EXTRA: begin
          if (step_count_q >= CNT_W'(home_extra_steps_q)) begin
            move_dir_d = 1'b1;
            reload     = 1'b1;
            phase_d    = PH_LATCH_FLD;
          end else begin
            stepping = 1'b1;
          end
        end
        PH_LATCH_FLD: begin
          if (in_latched) begin
            step_count_d = '0;
            phase_d      = PH_LEAVE_OPTO;
          end
        end
        PH_LEAVE_OPTO: begin
          if (!in_opto) begin
            step_count_d = '0;
            phase_d      = PH_TRAVEL;
          end
          stepping = 1'b1;
        end
        PH_TRAVEL: begin
          if (step_count_q >= target_steps_q) begin
            pin_level_d  = 1'b0;
            step_phase_d = 1'b0;
            active_d     = 1'b0;
            valid_flag_d = 1'b1;
            phase_d      = PH_IDLE;
            done         = 1'b1;
          end else begin
            stepping = 1'b1;
          end
        end
        default: begin
          // idle phase and the unused code both start a new homing run
          step_phase_d = 1'b0;
          move_dir_d   = 1'b0;
          reload       = 1'b1;
          step_count_d = '0;
          phase_d      = PH_LATCH_HOME;
        end
      endcase

      // step pin toggles, a step is counted on the rising level
      if (stepping) begin
        if (step_phase_d) begin
          pin_level_d = 1'b1;
          if (step_count_d != CNT_MAX) step_count_d = step_count_d + 1'b1;
        end else begin
          pin_level_d = 1'b0;
        end
        step_phase_d = !step_phase_d;
      end
    end
  end

  // result word for this transaction
  always_comb begin
    out_data_d      = '0;
    out_data_d[0]   = accepted;
    out_data_d[1]   = pin_level_d;
    out_data_d[2]   = active_d && (phase_d != PH_IDLE);
    out_data_d[3]   = move_dir_d;
    out_data_d[4]   = reload;
    out_data_d[12:5] = move_dir_d ? field_ramp_rate_q : home_ramp_rate_q;
    out_data_d[13]  = active_d;
    out_data_d[14]  = done;
    out_data_d[15]  = valid_flag_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      step_count_q   <= '0;
      step_phase_q   <= 1'b0;
      target_steps_q <= TARGET_STEPS_RST;
      active_q       <= 1'b0;
      valid_flag_q   <= 1'b0;
      move_dir_q     <= 1'b0;
      pin_level_q    <= 1'b0;
    end else if (in_fire) begin
      phase_q        <= phase_d;
      step_count_q   <= step_count_d;
      step_phase_q   <= step_phase_d;
      target_steps_q <= target_steps_d;
      active_q       <= active_d;
      valid_flag_q   <= valid_flag_d;
      move_dir_q     <= move_dir_d;
      pin_level_q    <= pin_level_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

FILE: bench/shp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shp_checker - result checker for the stepper homing positioner
// Watches the input, result and configuration channels, keeps its own copy
// of the sequencer state and registers, predicts the driver controls for
// every input transaction and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module shp_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream, observed
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // tdata: [15:0] target_um, [16] opto_engaged, [17] driver_latched
  input  logic [shp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: [0] kind
  input  logic                           s_axis_tuser,
  // result stream, observed
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [shp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // configuration port, observed
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [shp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [shp_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                           pready,
  // predictions still waiting for their result
  output int unsigned                    pending_o,
  output int unsigned                    fail_count_o
);

  import shp_pkg::*;

  // one set of driver controls, as returned per input transaction
  typedef struct packed {
    logic              accepted;
    logic              step_level;
    logic              driver_enable;
    logic              direction;
    logic              speed_reload;
    logic [RATE_W-1:0] rate_req;
    logic              busy;
    logic              done;
    logic              pos_valid;
  } drive_ctrl_t;

  // sequencer state
  logic [PHASE_W-1:0] seq_phase;
  logic [CNT_W-1:0]   step_cnt;
  logic [CNT_W-1:0]   goal_steps;
  logic               step_toggle;
  logic               running;
  logic               pos_ok;
  logic               toward_field;
  logic               pin_high;

  // register copies
  logic [EXTRA_W-1:0] extra_steps_cfg;
  logic [RATE_W-1:0]  home_rate_cfg;
  logic [RATE_W-1:0]  field_rate_cfg;

  drive_ctrl_t driver_ctrl_q[$];

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // one step pin toggle, a step counts on the rising level
  task automatic take_step();
    if (step_toggle) begin
      pin_high = 1'b1;
      step_cnt = sat_inc(step_cnt);
    end else begin
      pin_high = 1'b0;
    end
    step_toggle = ~step_toggle;
  endtask

  // advance the sequencer by one input transaction and form its controls
  task automatic predict_driver_ctrl(input logic kind, input logic [TARGET_UM_W-1:0] tum,
                                     input logic opto, input logic latched,
                                     output drive_ctrl_t r);
    int unsigned scaled;
    logic        moving;
    r = '0;
    moving = 1'b0;
    if (kind == KIND_START) begin
      // a start while busy is dropped
      if (!running) begin
        scaled = (int'(tum) * MICROSTEPS) / 100;
        r.accepted = 1'b1;
        running    = 1'b1;
        seq_phase  = PH_IDLE;
        goal_steps = (scaled > CNT_MAX) ? CNT_MAX : CNT_W'(scaled);
      end
    end else if (running) begin
      case (seq_phase)
        PH_LATCH_HOME: begin
          if (latched) seq_phase = PH_SEEK_OPTO;
        end
        PH_SEEK_OPTO: begin
          step_cnt = sat_inc(step_cnt);
          if (opto) begin
            step_cnt  = '0;
            seq_phase = PH_EXTRA;
          end else begin
            moving = 1'b1;
          end
        end
        PH_EXTRA: begin
          if (step_cnt >= CNT_W'(extra_steps_cfg)) begin
            toward_field   = 1'b1;
            r.speed_reload = 1'b1;
            seq_phase      = PH_LATCH_FLD;
          end else begin
            moving = 1'b1;
          end
        end
        PH_LATCH_FLD: begin
          if (latched) begin
            step_cnt  = '0;
            seq_phase = PH_LEAVE_OPTO;
          end
        end
        PH_LEAVE_OPTO: begin
          if (!opto) begin
            step_cnt  = '0;
            seq_phase = PH_TRAVEL;
          end
          moving = 1'b1;
        end
        PH_TRAVEL: begin
          if (step_cnt >= goal_steps) begin
            pin_high    = 1'b0;
            step_toggle = 1'b0;
            running     = 1'b0;
            pos_ok      = 1'b1;
            seq_phase   = PH_IDLE;
            r.done      = 1'b1;
          end else begin
            moving = 1'b1;
          end
        end
        // idle phase of an accepted start, and the unused code
        default: begin
          step_toggle    = 1'b0;
          toward_field   = 1'b0;
          r.speed_reload = 1'b1;
          step_cnt       = '0;
          seq_phase      = PH_LATCH_HOME;
        end
      endcase
      if (moving) take_step();
    end
    r.step_level     = pin_high;
    r.driver_enable  = running && (seq_phase != PH_IDLE);
    r.direction      = toward_field;
    r.rate_req       = toward_field ? field_rate_cfg : home_rate_cfg;
    r.busy           = running;
    r.pos_valid      = pos_ok;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // watch all three channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    drive_ctrl_t want;
    drive_ctrl_t pred;
    if (!rst_ni) begin
      seq_phase       = PH_IDLE;
      step_cnt        = '0;
      goal_steps      = TARGET_STEPS_RST;
      step_toggle     = 1'b0;
      running         = 1'b0;
      pos_ok          = 1'b0;
      toward_field    = 1'b0;
      pin_high        = 1'b0;
      extra_steps_cfg = HOME_EXTRA_STEPS_RST;
      home_rate_cfg   = HOME_RAMP_RATE_RST;
      field_rate_cfg  = FIELD_RAMP_RATE_RST;
      driver_ctrl_q.delete();
      fail_count_o    = 0;
      pending_o      <= 0;
    end else begin
      // result transaction against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (driver_ctrl_q.size() == 0) begin
          $error("result transaction with no prediction waiting: tdata %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = driver_ctrl_q.pop_front();
          compare_field("accepted",       want.accepted,       m_axis_tdata[0]);
          compare_field("step_level",     want.step_level,     m_axis_tdata[1]);
          compare_field("driver_enable",  want.driver_enable,  m_axis_tdata[2]);
          compare_field("direction",      want.direction,      m_axis_tdata[3]);
          compare_field("speed_reload",   want.speed_reload,   m_axis_tdata[4]);
          compare_field("rate_req",       want.rate_req,       m_axis_tdata[12:5]);
          compare_field("busy_res",       want.busy,           m_axis_tdata[13]);
          compare_field("done_res",       want.done,           m_axis_tdata[14]);
          compare_field("pos_valid",      want.pos_valid,      m_axis_tdata[15]);
        end
      end
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[REG_IDX_W+1:2])
          REG_HOME_EXTRA_STEPS: extra_steps_cfg = pwdata[EXTRA_W-1:0];
          REG_HOME_RAMP_RATE:   home_rate_cfg   = pwdata[RATE_W-1:0];
          REG_FIELD_RAMP_RATE:  field_rate_cfg  = pwdata[RATE_W-1:0];
          default: ;
        endcase
      end
      // input transaction
      if (s_axis_tvalid && s_axis_tready) begin
        predict_driver_ctrl(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[16],
                            s_axis_tdata[17], pred);
        driver_ctrl_q.push_back(pred);
      end
      pending_o <= driver_ctrl_q.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the stepper homing positioner
// Drives start and tick transactions through the homing and positioning
// sequence under several register settings and stall patterns; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  import shp_pkg::*;

  // largest target used by noise transactions and the steps it gives
  localparam int unsigned NOISE_UM_MAX    = 255;
  localparam int unsigned NOISE_STEPS_MAX = (NOISE_UM_MAX * MICROSTEPS) / 100;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int unsigned            pending_results;
  int unsigned            fail_count;
  int unsigned            tx_idle_pct = 0;
  int unsigned            rx_idle_pct = 0;
  int unsigned            items_sent = 0;
  logic [EXTRA_W-1:0]     extra_now = HOME_EXTRA_STEPS_RST;

  always #5 clk_i = ~clk_i;

  stepper_homing_positioner_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  shp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .pending_o     (pending_results),
    .fail_count_o  (fail_count)
  );

  // result side stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  // one input transaction, with random sender gaps ahead of it
  task automatic push_item(input logic kind, input logic [TARGET_UM_W-1:0] tum,
                           input logic opto, input logic latched);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'b0, latched, opto, tum};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic tick(input logic opto, input logic latched);
    push_item(KIND_TICK, 16'($urandom), opto, latched);
  endtask

  // stop sending and wait for every predicted result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_HOME_EXTRA_STEPS) extra_now = value;
    // bus returns to idle between writes
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] extra, input logic [7:0] home_rate,
                          input logic [7:0] field_rate);
    write_reg(REG_HOME_EXTRA_STEPS, extra);
    write_reg(REG_HOME_RAMP_RATE, home_rate);
    write_reg(REG_FIELD_RAMP_RATE, field_rate);
  endtask

  // well formed homing and positioning run with random side fields
  task automatic run_move(input logic [TARGET_UM_W-1:0] tum, input int unsigned seek_ticks);
    int unsigned goal;
    goal = (tum * MICROSTEPS) / 100;
    push_item(KIND_START, tum, coin(), coin());
    tick(coin(), coin());
    // wait for the driver latch toward home
    repeat ($urandom_range(3)) tick(coin(), 1'b0);
    tick(coin(), 1'b1);
    // seek the opto
    repeat (seek_ticks) tick(1'b0, coin());
    tick(1'b1, coin());
    // extra steps, with stray starts that must be dropped
    repeat (2 * extra_now + 3) begin
      if ($urandom_range(15) == 0) push_item(KIND_START, 16'($urandom), coin(), coin());
      tick(coin(), 1'b0);
    end
    // wait for the latch toward the field
    repeat ($urandom_range(3)) tick(coin(), 1'b0);
    tick(coin(), 1'b1);
    // leave the opto, then travel to the target
    repeat ($urandom_range(6)) tick(1'b1, coin());
    tick(1'b0, coin());
    repeat (2 * goal + 3) tick(coin(), coin());
  endtask

  // bring the block back to idle from any state a noise burst can leave
  task automatic recover();
    repeat (2 * extra_now + 12) tick(1'b1, 1'b1);
    repeat (2 * NOISE_STEPS_MAX + 8) tick(1'b0, coin());
  endtask

  task automatic random_phase(input int unsigned upto);
    while (items_sent < upto) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 12))
          push_item(coin(), 16'($urandom_range(NOISE_UM_MAX)), coin(), coin());
        recover();
      end else if ($urandom_range(4) == 0) begin
        run_move(16'($urandom_range(151, 700)), $urandom_range(12));
      end else begin
        run_move(16'($urandom_range(150)), $urandom_range(12));
      end
      if ($urandom_range(9) == 0) drain();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ticks while idle, start with zero target, start while busy, early phases
    push_item(KIND_TICK, 16'h0000, 1'b0, 1'b0);
    push_item(KIND_TICK, 16'hffff, 1'b1, 1'b1);
    push_item(KIND_START, 16'h0000, 1'b1, 1'b0);
    push_item(KIND_START, 16'hffff, 1'b0, 1'b1);
    push_item(KIND_TICK, 16'h1234, 1'b1, 1'b1);
    push_item(KIND_TICK, 16'h0000, 1'b1, 1'b0);
    push_item(KIND_TICK, 16'h0000, 1'b0, 1'b1);
    push_item(KIND_TICK, 16'h0000, 1'b0, 1'b0);
    push_item(KIND_TICK, 16'h0000, 1'b1, 1'b0);
    recover();
    drain();

    // sender idles lightly, receiver heavily
    set_regs(8'd0, 8'd0, 8'd255);
    tx_idle_pct = 14;
    rx_idle_pct <= 64;
    random_phase(700);
    drain();

    // roles swapped
    set_regs(8'd3, 8'd255, 8'd0);
    tx_idle_pct = 64;
    rx_idle_pct <= 14;
    random_phase(1300);
    drain();

    // no stalls, largest extra steps
    set_regs(8'd255, 8'($urandom), 8'($urandom));
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_move(16'($urandom_range(151, 700)), $urandom_range(12));
    drain();
    repeat (4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/shp_pkg.sv
sv/stepper_homing_positioner_top.sv
bench/shp_checker.sv
bench/tb_top.sv
